// ----- src/pfh_pkg.sv -----
// shared types, constants and codes for the periodic five-point stencil core
`timescale 1ns / 1ps

package pfh_pkg;

    localparam int GRID_ROWS = 64;
    localparam int GRID_COLS = 64;

    localparam int IDX_W  = 6;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 32;
    localparam int CIDX_W = 2;

    // stencil operand, product and accumulator widths
    localparam int OPND_W = 36;
    localparam int HALF_W = 16;
    localparam int PROD_W = OPND_W + HALF_W + 1;
    localparam int ACC_W  = 56;

    localparam logic [CFG_W-1:0] COEFF_RESET = 32'h0001_0000;

    localparam logic [CIDX_W-1:0] CFG_DIAG = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_X    = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_Y    = 2'd2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [2:0] MAC_LAST = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_C,
        S_RD_D,
        S_RD_U,
        S_RD_R,
        S_RD_L,
        S_DYY,
        S_MUL,
        S_DRAIN,
        S_SAT
    } state_t;

    typedef struct packed {
        logic valid;
        logic clear;
        logic lo_half;
        logic negate;
    } mac_ctl_t;

endpackage

// ----- src/pfh_grid_ram.sv -----
// grid value memory, one write port and one registered read port
`timescale 1ns / 1ps

module pfh_grid_ram #(
    parameter int DEPTH = pfh_pkg::GRID_ROWS * pfh_pkg::GRID_COLS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [pfh_pkg::DATA_W-1:0]  wdata,
    input  logic [AW-1:0]               raddr,
    output logic [pfh_pkg::DATA_W-1:0]  rdata
);
    import pfh_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/pfh_mac_unit.sv -----
// shared multiplier with registered product and floor-shifting accumulator
`timescale 1ns / 1ps

module pfh_mac_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pfh_pkg::mac_ctl_t                   ctl,
    input  logic signed [pfh_pkg::OPND_W-1:0]   opnd,
    input  logic [pfh_pkg::HALF_W-1:0]          coeff,
    output logic signed [pfh_pkg::ACC_W-1:0]    acc
);
    import pfh_pkg::*;

    mac_ctl_t                   ctl_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [ACC_W-1:0]    term;
    logic signed [ACC_W-1:0]    base;

    assign prod_next = PROD_W'(opnd * $signed({1'b0, coeff}));

    // low half keeps floor of product over 2^16, high half is already aligned
    always_comb
    begin
        if (ctl_reg.lo_half)
        begin
            term = ACC_W'(prod_reg >>> HALF_W);
        end
        else
        begin
            term = ACC_W'(prod_reg);
        end
        base = ctl_reg.clear ? '0 : acc_reg;
        acc_next = ctl_reg.negate ? base - term : base + term;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (ctl_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ----- src/periodic_five_point_helmholtz_stencil_core.sv -----
// Periodic five-point Helmholtz stencil core. A write item (kind 0) stores a signed Q16.16
// value at (row mod ROWS, col mod COLS), and in_stall stays low so writes may follow each
// other in every cycle. A query item (kind 1) reads the cell and its four
// wrapping neighbours one after another through the single read port of the grid memory,
// then runs six passes of one shared 36x17 multiplier (low and high coefficient halves for
// the diagonal, row and column terms); in_stall stays high until the result is registered,
// which waits while an earlier result is held by out_stall. Query only cells written since
// reset. The user must write coefficients only while the block is idle (not enforced).
`timescale 1ns / 1ps

module periodic_five_point_helmholtz_stencil_core #(
    parameter int ROWS = pfh_pkg::GRID_ROWS,
    parameter int COLS = pfh_pkg::GRID_COLS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic [pfh_pkg::IDX_W-1:0]           row,
    input  logic [pfh_pkg::IDX_W-1:0]           col,
    input  logic signed [pfh_pkg::DATA_W-1:0]   value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [pfh_pkg::DATA_W-1:0]   result,
    output logic                                saturated,
    input  logic                                cfg_we,
    input  logic [pfh_pkg::CIDX_W-1:0]          cfg_index,
    input  logic [pfh_pkg::CFG_W-1:0]           cfg_data
);
    import pfh_pkg::*;

    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int NIDX  = 2 ** IDX_W;

    state_t                     state_reg, state_next;
    logic [RW-1:0]              r_reg, r_next;
    logic [CW-1:0]              c_reg, c_next;
    logic [2:0]                 step_reg, step_next;
    logic signed [OPND_W-1:0]   u_reg, u_next;
    logic signed [OPND_W-1:0]   nsum_reg, nsum_next;
    logic signed [OPND_W-1:0]   dxx_reg, dxx_next;
    logic signed [OPND_W-1:0]   dyy_reg, dyy_next;
    logic [CFG_W-1:0]           diag_reg, x_reg, y_reg;
    logic                       out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0]   result_reg, result_next;
    logic                       sat_reg, sat_next;

    logic [RW-1:0]              row_mod [NIDX];
    logic [CW-1:0]              col_mod [NIDX];
    logic [RW-1:0]              rp, rm, rd_r;
    logic [CW-1:0]              cp, cm, rd_c;
    logic [AW-1:0]              waddr, raddr;
    logic                       wr_en;
    logic [DATA_W-1:0]          rdata;
    logic signed [OPND_W-1:0]   rd_ext;

    mac_ctl_t                   mac_ctl;
    logic signed [OPND_W-1:0]   mac_opnd;
    logic [CFG_W-1:0]           mac_coeff_full;
    logic [HALF_W-1:0]          mac_coeff;
    logic signed [ACC_W-1:0]    acc;
    logic                       acc_in_range;
    logic                       accept;

    // index reduction tables, worked out at elaboration
    for (genvar k = 0; k < NIDX; k++)
    begin : g_mod
        assign row_mod[k] = RW'(k % ROWS);
        assign col_mod[k] = CW'(k % COLS);
    end

    assign rp = (r_reg == RW'(ROWS - 1)) ? '0 : r_reg + RW'(1);
    assign rm = (r_reg == '0) ? RW'(ROWS - 1) : r_reg - RW'(1);
    assign cp = (c_reg == CW'(COLS - 1)) ? '0 : c_reg + CW'(1);
    assign cm = (c_reg == '0) ? CW'(COLS - 1) : c_reg - CW'(1);

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign wr_en    = accept && (kind == KIND_WRITE);
    assign waddr    = AW'(AW'(row_mod[row]) * AW'(COLS) + AW'(col_mod[col]));
    assign raddr    = AW'(AW'(rd_r) * AW'(COLS) + AW'(rd_c));
    assign rd_ext   = OPND_W'($signed(rdata));

    pfh_grid_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (value),
        .raddr (raddr),
        .rdata (rdata)
    );

    pfh_mac_unit u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .opnd  (mac_opnd),
        .coeff (mac_coeff),
        .acc   (acc)
    );

    // neighbour read address per sequencer step
    always_comb
    begin
        case (state_reg)
            S_RD_D:
            begin
                rd_r = rp;
                rd_c = c_reg;
            end
            S_RD_U:
            begin
                rd_r = rm;
                rd_c = c_reg;
            end
            S_RD_R:
            begin
                rd_r = r_reg;
                rd_c = cp;
            end
            S_RD_L:
            begin
                rd_r = r_reg;
                rd_c = cm;
            end
            default:
            begin
                rd_r = r_reg;
                rd_c = c_reg;
            end
        endcase
    end

    // operand and coefficient half for each multiplier pass
    always_comb
    begin
        case (step_reg[2:1])
            2'd0:
            begin
                mac_opnd       = u_reg;
                mac_coeff_full = diag_reg;
            end
            2'd1:
            begin
                mac_opnd       = dxx_reg;
                mac_coeff_full = x_reg;
            end
            default:
            begin
                mac_opnd       = dyy_reg;
                mac_coeff_full = y_reg;
            end
        endcase
        mac_coeff       = step_reg[0] ? mac_coeff_full[CFG_W-1:HALF_W]
                                      : mac_coeff_full[HALF_W-1:0];
        mac_ctl.valid   = (state_reg == S_MUL);
        mac_ctl.clear   = (step_reg == 3'd0);
        mac_ctl.lo_half = !step_reg[0];
        mac_ctl.negate  = (step_reg[2:1] != 2'd0);
    end

    assign acc_in_range = (acc[ACC_W-1:DATA_W-1] == '0) || (acc[ACC_W-1:DATA_W-1] == '1);

    always_comb
    begin
        state_next     = state_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        step_next      = step_reg;
        u_next         = u_reg;
        nsum_next      = nsum_reg;
        dxx_next       = dxx_reg;
        dyy_next       = dyy_reg;
        result_next    = result_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (kind == KIND_QUERY))
                begin
                    r_next     = row_mod[row];
                    c_next     = col_mod[col];
                    state_next = S_RD_C;
                end
            end
            S_RD_C:
            begin
                state_next = S_RD_D;
            end
            S_RD_D:
            begin
                u_next     = rd_ext;
                state_next = S_RD_U;
            end
            S_RD_U:
            begin
                nsum_next  = rd_ext;
                state_next = S_RD_R;
            end
            S_RD_R:
            begin
                dxx_next   = nsum_reg + rd_ext - (u_reg <<< 1);
                state_next = S_RD_L;
            end
            S_RD_L:
            begin
                nsum_next  = rd_ext;
                state_next = S_DYY;
            end
            S_DYY:
            begin
                dyy_next   = nsum_reg + rd_ext - (u_reg <<< 1);
                step_next  = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == MAC_LAST)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_SAT;
            end
            S_SAT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    if (acc_in_range)
                    begin
                        result_next = DATA_W'(acc);
                        sat_next    = 1'b0;
                    end
                    else
                    begin
                        result_next = acc[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                                   : {1'b0, {(DATA_W-1){1'b1}}};
                        sat_next    = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diag_reg <= COEFF_RESET;
            x_reg    <= COEFF_RESET;
            y_reg    <= COEFF_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DIAG: diag_reg <= cfg_data;
                CFG_X:    x_reg    <= cfg_data;
                CFG_Y:    y_reg    <= cfg_data;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg      <= r_next;
        c_reg      <= c_next;
        u_reg      <= u_next;
        nsum_reg   <= nsum_next;
        dxx_reg    <= dxx_next;
        dyy_reg    <= dyy_next;
        result_reg <= result_next;
        sat_reg    <= sat_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign saturated = sat_reg;

`ifndef SYNTHESIS
    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (kind == KIND_QUERY) |=> state_reg == S_RD_C)
        else $error("query did not start the read sequence");

    a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (kind == KIND_WRITE) |=> state_reg == S_IDLE)
        else $error("write item left the idle state");

    a_result_from_sat: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_SAT))
        else $error("result shown outside the saturation step");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MUL |-> step_reg <= MAC_LAST)
        else $error("multiplier pass count overran");

    a_drain_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DRAIN |-> $past(state_reg == S_MUL) && $past(step_reg == MAC_LAST))
        else $error("accumulator drained before the last pass");
`endif

endmodule

// ----- tb/sv/stencil_checker.sv -----
// checker for the stencil core: mirrors grid and coefficients, predicts and compares results
`timescale 1ns / 1ps

module stencil_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              kind,
    input  logic [pfh_pkg::IDX_W-1:0]         row,
    input  logic [pfh_pkg::IDX_W-1:0]         col,
    input  logic signed [pfh_pkg::DATA_W-1:0] value,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic signed [pfh_pkg::DATA_W-1:0] result,
    input  logic                              saturated,
    input  logic                              cfg_we,
    input  logic [pfh_pkg::CIDX_W-1:0]        cfg_index,
    input  logic [pfh_pkg::CFG_W-1:0]         cfg_data,
    output int                                failures,
    output int                                outstanding
);
    import pfh_pkg::*;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic                     saturated;
    } op_value_t;

    logic signed [DATA_W-1:0] grid_copy [GRID_ROWS*GRID_COLS];
    logic [CFG_W-1:0]         diag_k;
    logic [CFG_W-1:0]         x_k;
    logic [CFG_W-1:0]         y_k;
    op_value_t                due_values [$];
    int                       fail_count = 0;

    assign failures = fail_count;

    // exact product, floored back to q16.16
    function automatic longint q16_scale(input logic signed [35:0] a,
                                         input logic [CFG_W-1:0] k);
        logic signed [68:0] full;
        full = a * $signed({1'b0, k});
        full = full >>> 16;
        return full[63:0];
    endfunction

    function automatic op_value_t helmholtz_at(input logic [IDX_W-1:0] r,
                                               input logic [IDX_W-1:0] c);
        int                 rr;
        int                 cc;
        int                 rdn;
        int                 rup;
        int                 crt;
        int                 clf;
        logic signed [35:0] u;
        logic signed [35:0] d2x;
        logic signed [35:0] d2y;
        longint             acc;
        op_value_t          o;
        rr  = int'(r) % GRID_ROWS;
        cc  = int'(c) % GRID_COLS;
        rdn = (rr + 1) % GRID_ROWS;
        rup = (rr + GRID_ROWS - 1) % GRID_ROWS;
        crt = (cc + 1) % GRID_COLS;
        clf = (cc + GRID_COLS - 1) % GRID_COLS;
        u   = grid_copy[rr*GRID_COLS + cc];
        d2x = grid_copy[rdn*GRID_COLS + cc] - 2 * u + grid_copy[rup*GRID_COLS + cc];
        d2y = grid_copy[rr*GRID_COLS + crt] - 2 * u + grid_copy[rr*GRID_COLS + clf];
        acc = q16_scale(u, diag_k) - q16_scale(d2x, x_k) - q16_scale(d2y, y_k);
        o.saturated = (acc > SAT_HI) || (acc < SAT_LO);
        if (acc > SAT_HI)
            acc = SAT_HI;
        else if (acc < SAT_LO)
            acc = SAT_LO;
        o.result = acc[DATA_W-1:0];
        return o;
    endfunction

    always @(posedge clk)
    begin
        op_value_t want;
        if (!rst_n)
        begin
            diag_k = COEFF_RESET;
            x_k    = COEFF_RESET;
            y_k    = COEFF_RESET;
            due_values.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DIAG: diag_k = cfg_data;
                    CFG_X:    x_k    = cfg_data;
                    CFG_Y:    y_k    = cfg_data;
                    default:  ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (due_values.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result %h saturated %b", $time, result, saturated);
                end
                else
                begin
                    want = due_values.pop_front();
                    if (result !== want.result)
                    begin
                        fail_count++;
                        $display("%0t: result expected %h actual %h", $time, want.result,
                                 result);
                    end
                    if (saturated !== want.saturated)
                    begin
                        fail_count++;
                        $display("%0t: saturated expected %b actual %b", $time,
                                 want.saturated, saturated);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (kind == KIND_WRITE)
                    grid_copy[(int'(row) % GRID_ROWS)*GRID_COLS + int'(col) % GRID_COLS] = value;
                else
                    due_values.push_back(helmholtz_at(row, col));
            end
            outstanding <= due_values.size();
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
// testbench top for the stencil core: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb;
    import pfh_pkg::*;

    localparam logic [CIDX_W-1:0] CFG_SPARE   = 2'd3;
    localparam logic [DATA_W-1:0] VAL_MAX     = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] VAL_MIN     = 32'h8000_0000;
    localparam logic [CFG_W-1:0]  COEFF_MAX   = 32'hFFFF_FFFF;
    localparam int                SETTLE_CYC  = 24;
    localparam int                PHASE_ITEMS = 215;
    localparam int                RAND_PHASES = 4;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic                     kind      = KIND_WRITE;
    logic [IDX_W-1:0]         row       = '0;
    logic [IDX_W-1:0]         col       = '0;
    logic signed [DATA_W-1:0] value     = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] result;
    logic                     saturated;
    logic                     cfg_we    = 1'b0;
    logic [CIDX_W-1:0]        cfg_index = CFG_DIAG;
    logic [CFG_W-1:0]         cfg_data  = '0;
    int                       failures;
    int                       outstanding;
    logic                     in_calm   = 1'b0;
    logic                     out_calm  = 1'b0;
    int                       out_hold  = 0;

    periodic_five_point_helmholtz_stencil_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .row       (row),
        .col       (col),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result),
        .saturated (saturated),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    stencil_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .row         (row),
        .col         (col),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result      (result),
        .saturated   (saturated),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // result side: a drawn stall is spent only while a result is waiting
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if ($urandom_range(0, 15) == 0)
                    out_calm = !out_calm;
                out_hold = out_calm ? 0 : $urandom_range(0, 7);
            end
            else if (out_valid && out_hold != 0)
                out_hold = out_hold - 1;
            out_stall <= (out_hold != 0);
        end
    end

    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] w;
        w = $urandom;
        case ($urandom_range(0, 7))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return w;
            3:       return w[0] ? '0 : '1;
            default: return {{11{w[20]}}, w[20:0]};
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_coeff();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return COEFF_MAX;
            2:       return COEFF_RESET;
            3:       return $urandom;
            default: return $urandom_range(0, 32'h3_FFFF);
        endcase
    endfunction

    // leaves in_valid high after the item is taken
    task automatic send_item(input logic k, input logic [IDX_W-1:0] r,
                             input logic [IDX_W-1:0] c, input logic [DATA_W-1:0] v);
        int gap;
        if ($urandom_range(0, 63) == 0)
            in_calm = !in_calm;
        gap = in_calm ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        row      <= r;
        col      <= c;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // unused index last, which the block must ignore
    task automatic load_coeffs(input logic [CFG_W-1:0] d, input logic [CFG_W-1:0] x,
                               input logic [CFG_W-1:0] y);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DIAG;
        cfg_data  <= d;
        @(posedge clk);
        cfg_index <= CFG_X;
        cfg_data  <= x;
        @(posedge clk);
        cfg_index <= CFG_Y;
        cfg_data  <= y;
        @(posedge clk);
        cfg_index <= CFG_SPARE;
        cfg_data  <= $urandom;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase();
        repeat (PHASE_ITEMS)
        begin
            send_item($urandom_range(0, 1) ? KIND_QUERY : KIND_WRITE,
                      IDX_W'($urandom_range(0, 63)), IDX_W'($urandom_range(0, 63)),
                      pick_value());
        end
        drain_results();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // whole grid first, so that no query touches an unwritten cell
        for (int r = 0; r < GRID_ROWS; r++)
            for (int c = 0; c < GRID_COLS; c++)
                send_item(KIND_WRITE, IDX_W'(r), IDX_W'(c), pick_value());

        // corner cell with wrapping neighbours, clipped high
        send_item(KIND_WRITE, 6'd0, 6'd0, VAL_MAX);
        send_item(KIND_WRITE, 6'd1, 6'd0, VAL_MIN);
        send_item(KIND_WRITE, 6'd63, 6'd0, VAL_MIN);
        send_item(KIND_WRITE, 6'd0, 6'd1, VAL_MIN);
        send_item(KIND_WRITE, 6'd0, 6'd63, VAL_MIN);
        send_item(KIND_QUERY, 6'd0, 6'd0, VAL_MAX);
        // opposite corner, clipped low
        send_item(KIND_WRITE, 6'd63, 6'd63, VAL_MIN);
        send_item(KIND_WRITE, 6'd62, 6'd63, VAL_MAX);
        send_item(KIND_WRITE, 6'd0, 6'd63, VAL_MAX);
        send_item(KIND_WRITE, 6'd63, 6'd62, VAL_MAX);
        send_item(KIND_WRITE, 6'd63, 6'd0, VAL_MAX);
        send_item(KIND_QUERY, 6'd63, 6'd63, VAL_MIN);
        send_item(KIND_QUERY, 6'd0, 6'd63, '0);
        send_item(KIND_QUERY, 6'd63, 6'd0, '1);
        send_item(KIND_WRITE, 6'd32, 6'd32, 32'h0001_8000);
        send_item(KIND_QUERY, 6'd32, 6'd32, '0);
        send_item(KIND_WRITE, 6'd5, 6'd5, 32'hFFFF_FFFF);
        send_item(KIND_QUERY, 6'd5, 6'd5, '0);
        drain_results();

        load_coeffs('0, '0, '0);
        run_phase();
        load_coeffs(COEFF_MAX, COEFF_MAX, COEFF_MAX);
        run_phase();
        load_coeffs(COEFF_MAX, '0, 32'h0000_0001);
        run_phase();
        repeat (RAND_PHASES)
        begin
            load_coeffs(pick_coeff(), pick_coeff(), pick_coeff());
            run_phase();
        end

        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
